[hdl/gpc_pkg.sv]
package gpc_pkg;

  // Grid geometry
  localparam int unsigned MAX_DIM = 512;
  localparam int unsigned DIM_W   = 10;
  localparam int unsigned POS_W   = $clog2(MAX_DIM);

  // Path counts
  localparam int unsigned CNT_W = 25;
  localparam logic [CNT_W-1:0] PATH_MOD = CNT_W'(20170805);

  // Cell type codes
  localparam int unsigned TYPE_W = 2;
  localparam logic [TYPE_W-1:0] TYPE_FREE    = 2'd0;
  localparam logic [TYPE_W-1:0] TYPE_BLOCKED = 2'd1;
  localparam logic [TYPE_W-1:0] TYPE_NOTURN  = 2'd2;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_ROWS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_COLS = 1'd1;

  // Position of one cell in the grid
  typedef struct packed {
    logic [POS_W-1:0] col;
    logic             first_col;
    logic             first_row;
    logic             last_cell;
  } pos_t;

  // Modular add of two reduced counts
  function automatic logic [CNT_W-1:0] add_mod(input logic [CNT_W-1:0] a,
                                               input logic [CNT_W-1:0] b);
    logic [CNT_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, PATH_MOD}) begin
      s = s - {1'b0, PATH_MOD};
    end
    return s[CNT_W-1:0];
  endfunction

endpackage

[hdl/gpc_cell_if.sv]
interface gpc_cell_if;
  logic                         valid;
  logic                         ready;
  logic [gpc_pkg::TYPE_W-1:0]   cell_type;

  modport source (output valid, output cell_type, input ready);
  modport sink   (input valid, input cell_type, output ready);
endinterface

interface gpc_count_if;
  logic                         valid;
  logic                         ready;
  logic [gpc_pkg::CNT_W-1:0]    path_count;

  modport source (output valid, output path_count, input ready);
  modport sink   (input valid, input path_count, output ready);
endinterface

[hdl/gpc_ctrl.sv]
module gpc_ctrl (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [gpc_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [gpc_pkg::DIM_W-1:0]       cfg_data_i,
  input  logic                            accept_i,
  output gpc_pkg::pos_t                   pos_o
);

  logic [gpc_pkg::DIM_W-1:0] num_rows_q, num_cols_q;
  logic [gpc_pkg::DIM_W-1:0] rows_eff, cols_eff;
  logic [gpc_pkg::POS_W-1:0] col_q, col_d, row_q, row_d;
  logic [gpc_pkg::DIM_W-1:0] col_next, row_next;
  logic                      last_col, last_row;

  // Clamp dimensions to 1..MAX_DIM
  always_comb begin
    rows_eff = num_rows_q;
    if (num_rows_q == '0) begin
      rows_eff = gpc_pkg::DIM_W'(1);
    end else if (num_rows_q > gpc_pkg::DIM_W'(gpc_pkg::MAX_DIM)) begin
      rows_eff = gpc_pkg::DIM_W'(gpc_pkg::MAX_DIM);
    end
    cols_eff = num_cols_q;
    if (num_cols_q == '0) begin
      cols_eff = gpc_pkg::DIM_W'(1);
    end else if (num_cols_q > gpc_pkg::DIM_W'(gpc_pkg::MAX_DIM)) begin
      cols_eff = gpc_pkg::DIM_W'(gpc_pkg::MAX_DIM);
    end
  end

  // Detect row and grid end, advance the position
  always_comb begin
    col_next = gpc_pkg::DIM_W'(col_q) + gpc_pkg::DIM_W'(1);
    row_next = gpc_pkg::DIM_W'(row_q) + gpc_pkg::DIM_W'(1);
    last_col = col_next >= cols_eff;
    last_row = row_next >= rows_eff;
    col_d    = col_q;
    row_d    = row_q;
    if (accept_i) begin
      if (last_col) begin
        col_d = '0;
        row_d = last_row ? '0 : row_next[gpc_pkg::POS_W-1:0];
      end else begin
        col_d = col_next[gpc_pkg::POS_W-1:0];
      end
    end
  end

  assign pos_o.col       = col_q;
  assign pos_o.first_col = (col_q == '0);
  assign pos_o.first_row = (row_q == '0);
  assign pos_o.last_cell = last_col && last_row;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_rows_q <= gpc_pkg::DIM_W'(1);
      num_cols_q <= gpc_pkg::DIM_W'(1);
      col_q      <= '0;
      row_q      <= '0;
    end else begin
      if (cfg_we_i && cfg_idx_i == gpc_pkg::REG_NUM_ROWS) begin
        num_rows_q <= cfg_data_i;
      end
      if (cfg_we_i && cfg_idx_i == gpc_pkg::REG_NUM_COLS) begin
        num_cols_q <= cfg_data_i;
      end
      col_q <= col_d;
      row_q <= row_d;
    end
  end

endmodule

[hdl/gpc_line_mem.sv]
module gpc_line_mem (
  input  logic                          clk_i,
  input  logic                          we_i,
  input  logic [gpc_pkg::POS_W-1:0]     waddr_i,
  input  logic [gpc_pkg::CNT_W-1:0]     wdata_i,
  input  logic                          re_i,
  input  logic [gpc_pkg::POS_W-1:0]     raddr_i,
  output logic [gpc_pkg::CNT_W-1:0]     rdata_o
);

  logic [gpc_pkg::CNT_W-1:0] mem_q [gpc_pkg::MAX_DIM];
  logic [gpc_pkg::CNT_W-1:0] rdata_q;

  // Store the downward count of each column of the previous row
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read, held while no new request is taken
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hdl/grid_path_count_no_turn_cells_unit.sv]
// Grid path counter with no-turn cells.
// Cells enter on in_i (cell_type: free, blocked, no turn) in row-major order,
// one request per cycle. The grid size comes from num_rows (index 0) and
// num_cols (index 1) on the write port; write them only while idle.
// On the last cell of the grid one request leaves on out_o carrying the
// number of right/down paths from the top-left to the bottom-right corner,
// modulo 20170805.
// Throughput: one cell per cycle while out_o does not stall. The last cell
// waits in the input stage while the line-store read completes, and its sum
// loads the result register, which drives out_o.valid.
// The line store keeps one downward count per column, read when the cell is
// taken; a write to the same column in the cycle of that read is forwarded.
// Reset clears the position to the top-left corner and sets both dimensions
// to 1. The line store is not cleared; the first row never reads it.
// When out_o stalls, the last cell waits in the input stage and in_i drops
// ready; cells that produce no result keep flowing.
module grid_path_count_no_turn_cells_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [gpc_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [gpc_pkg::DIM_W-1:0]       cfg_data_i,
  gpc_cell_if.sink                        in_i,
  gpc_count_if.source                     out_o
);

  gpc_pkg::pos_t             pos;
  logic                      accept;

  logic                      s1_valid_q;
  logic [gpc_pkg::TYPE_W-1:0] s1_type_q;
  gpc_pkg::pos_t             s1_pos_q;
  logic                      s1_adv;

  logic [gpc_pkg::CNT_W-1:0] left_q;
  logic                      fwd_q;
  logic [gpc_pkg::CNT_W-1:0] fwd_data_q;
  logic [gpc_pkg::CNT_W-1:0] mem_rdata, above;

  logic [gpc_pkg::CNT_W-1:0] r_cnt, d_cnt, sum, right_pass, down_pass;

  logic                      out_valid_q;
  logic [gpc_pkg::CNT_W-1:0] path_count_q;
  logic                      out_free;

  // Handshake: the input stage frees when its cell moves on
  assign out_free    = !out_valid_q || out_o.ready;
  assign s1_adv      = s1_valid_q && (!s1_pos_q.last_cell || out_free);
  assign in_i.ready  = !s1_valid_q || s1_adv;
  assign accept      = in_i.valid && in_i.ready;

  gpc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .accept_i   (accept),
    .pos_o      (pos)
  );

  gpc_line_mem u_line_mem (
    .clk_i   (clk_i),
    .we_i    (s1_adv),
    .waddr_i (s1_pos_q.col),
    .wdata_i (down_pass),
    .re_i    (accept),
    .raddr_i (pos.col),
    .rdata_o (mem_rdata)
  );

  assign above = fwd_q ? fwd_data_q : mem_rdata;

  // Counts arriving at the current cell
  always_comb begin
    if (s1_pos_q.first_col) begin
      r_cnt = s1_pos_q.first_row ? gpc_pkg::CNT_W'(1) : '0;
    end else begin
      r_cnt = left_q;
    end
    d_cnt = s1_pos_q.first_row ? '0 : above;
    if (s1_type_q == gpc_pkg::TYPE_BLOCKED) begin
      r_cnt = '0;
      d_cnt = '0;
    end
    sum = gpc_pkg::add_mod(r_cnt, d_cnt);
  end

  // Counts passed on to the right and downward neighbors
  always_comb begin
    case (s1_type_q)
      gpc_pkg::TYPE_FREE: begin
        right_pass = sum;
        down_pass  = sum;
      end
      gpc_pkg::TYPE_NOTURN: begin
        right_pass = r_cnt;
        down_pass  = d_cnt;
      end
      default: begin
        right_pass = '0;
        down_pass  = '0;
      end
    endcase
  end

  // Input stage and forwarding of a same-column write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      left_q     <= '0;
    end else begin
      if (accept) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        left_q <= s1_pos_q.last_cell ? '0 : right_pass;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_type_q  <= in_i.cell_type;
      s1_pos_q   <= pos;
      fwd_q      <= s1_adv && (s1_pos_q.col == pos.col);
      fwd_data_q <= down_pass;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      if (s1_adv && s1_pos_q.last_cell) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_pos_q.last_cell) begin
      path_count_q <= sum;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.path_count = path_count_q;

endmodule

[dv/tb.sv]
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Type code with no package name: counts like a free cell, passes nothing
  localparam logic [gpc_pkg::TYPE_W-1:0] TYPE_SPARE = 2'd3;

  localparam int unsigned RANDOM_CELLS = 200;
  localparam int unsigned STALL_LIMIT  = 4000;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned SHOW_LIMIT   = 100;

  // Directed stimulus table
  typedef enum logic [1:0] {
    STEP_CELL,
    STEP_ROWS,
    STEP_COLS
  } step_op_e;

  typedef struct packed {
    step_op_e                   op;
    logic [gpc_pkg::DIM_W-1:0]  val;
    logic                       pinned;
    logic [gpc_pkg::CNT_W-1:0]  want;
  } step_t;

  localparam step_t PLAN [25] = '{
    // 1x1 grid after reset, one of each cell type
    '{STEP_CELL, 10'(gpc_pkg::TYPE_FREE),    1'b1, 25'd1},
    '{STEP_CELL, 10'(gpc_pkg::TYPE_BLOCKED), 1'b1, 25'd0},
    '{STEP_CELL, 10'(gpc_pkg::TYPE_NOTURN),  1'b1, 25'd1},
    '{STEP_CELL, 10'(TYPE_SPARE),            1'b1, 25'd1},
    // 2x2 all free, then 2x2 all no-turn
    '{STEP_ROWS, 10'd2,                      1'b0, 25'd0},
    '{STEP_COLS, 10'd2,                      1'b0, 25'd0},
    '{STEP_CELL, 10'(gpc_pkg::TYPE_FREE),    1'b0, 25'd0},
    '{STEP_CELL, 10'(gpc_pkg::TYPE_FREE),    1'b0, 25'd0},
    '{STEP_CELL, 10'(gpc_pkg::TYPE_FREE),    1'b0, 25'd0},
    '{STEP_CELL, 10'(gpc_pkg::TYPE_FREE),    1'b1, 25'd2},
    '{STEP_CELL, 10'(gpc_pkg::TYPE_NOTURN),  1'b0, 25'd0},
    '{STEP_CELL, 10'(gpc_pkg::TYPE_NOTURN),  1'b0, 25'd0},
    '{STEP_CELL, 10'(gpc_pkg::TYPE_NOTURN),  1'b0, 25'd0},
    '{STEP_CELL, 10'(gpc_pkg::TYPE_NOTURN),  1'b1, 25'd0},
    // 2x3 grid, columns shrink in the middle of the second row
    '{STEP_COLS, 10'd3,                      1'b0, 25'd0},
    '{STEP_CELL, 10'(gpc_pkg::TYPE_FREE),    1'b0, 25'd0},
    '{STEP_CELL, 10'(gpc_pkg::TYPE_NOTURN),  1'b0, 25'd0},
    '{STEP_CELL, 10'(gpc_pkg::TYPE_FREE),    1'b0, 25'd0},
    '{STEP_CELL, 10'(gpc_pkg::TYPE_FREE),    1'b0, 25'd0},
    '{STEP_COLS, 10'd1,                      1'b0, 25'd0},
    '{STEP_CELL, 10'(gpc_pkg::TYPE_FREE),    1'b0, 25'd0},
    // 3x1 grid, rows shrink after the first cell
    '{STEP_ROWS, 10'd3,                      1'b0, 25'd0},
    '{STEP_CELL, 10'(gpc_pkg::TYPE_FREE),    1'b0, 25'd0},
    '{STEP_ROWS, 10'd1,                      1'b0, 25'd0},
    '{STEP_CELL, 10'(gpc_pkg::TYPE_NOTURN),  1'b0, 25'd0}
  };

  // Counts held per cell: arrived moving right, arrived moving down
  typedef struct packed {
    logic [gpc_pkg::CNT_W-1:0]  rt;
    logic [gpc_pkg::CNT_W-1:0]  dn;
    logic [gpc_pkg::TYPE_W-1:0] kind;
  } cell_counts_t;

  logic                          clk;
  logic                          rst_n;
  logic                          cfg_we;
  logic [gpc_pkg::CFG_IDX_W-1:0] cfg_idx;
  logic [gpc_pkg::DIM_W-1:0]     cfg_data;

  gpc_cell_if  cell_ch ();
  gpc_count_if count_ch ();

  grid_path_count_no_turn_cells_unit u_top (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_i       (cell_ch),
    .out_o      (count_ch)
  );

  // Grid model state
  cell_counts_t              line_store [gpc_pkg::MAX_DIM];
  cell_counts_t              left_cell = '0;
  int unsigned               grid_row = 0;
  int unsigned               grid_col = 0;
  logic [gpc_pkg::DIM_W-1:0] rows_reg = 10'd1;
  logic [gpc_pkg::DIM_W-1:0] cols_reg = 10'd1;

  logic [gpc_pkg::CNT_W-1:0] path_counts_due [$];
  int unsigned               faults = 0;
  int unsigned               cells_sent = 0;
  bit                        calm = 1'b0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic int unsigned dim_eff(input logic [gpc_pkg::DIM_W-1:0] v);
    if (v == '0) return 1;
    if (v > gpc_pkg::MAX_DIM) return gpc_pkg::MAX_DIM;
    return v;
  endfunction

  function automatic logic [gpc_pkg::CNT_W-1:0] mod_sum(
      input logic [gpc_pkg::CNT_W-1:0] a, input logic [gpc_pkg::CNT_W-1:0] b);
    int unsigned s;
    s = int'(a) + int'(b);
    return gpc_pkg::CNT_W'(s % int'(gpc_pkg::PATH_MOD));
  endfunction

  // Count a neighbor hands on, to the right or downward
  function automatic logic [gpc_pkg::CNT_W-1:0] hand_on(input cell_counts_t c,
                                                        input bit rightward);
    case (c.kind)
      gpc_pkg::TYPE_FREE:   return mod_sum(c.rt, c.dn);
      gpc_pkg::TYPE_NOTURN: return rightward ? c.rt : c.dn;
      default:              return '0;
    endcase
  endfunction

  // Advance the grid by one cell; report the corner count on the last cell
  function void take_cell(input logic [gpc_pkg::TYPE_W-1:0] kind, output bit done,
                          output logic [gpc_pkg::CNT_W-1:0] total);
    cell_counts_t cur;
    int unsigned  rows_n;
    int unsigned  cols_n;
    rows_n = dim_eff(rows_reg);
    cols_n = dim_eff(cols_reg);
    cur.kind = kind;
    if (grid_col == 0) cur.rt = (grid_row == 0) ? gpc_pkg::CNT_W'(1) : '0;
    else cur.rt = hand_on(left_cell, 1'b1);
    cur.dn = (grid_row == 0) ? '0 : hand_on(line_store[grid_col], 1'b0);
    if (kind == gpc_pkg::TYPE_BLOCKED) begin
      cur.rt = '0;
      cur.dn = '0;
    end
    line_store[grid_col] = cur;
    left_cell = cur;
    done = 1'b0;
    total = '0;
    if (grid_col + 1 >= cols_n) begin
      grid_col = 0;
      if (grid_row + 1 >= rows_n) begin
        done = 1'b1;
        total = mod_sum(cur.rt, cur.dn);
        grid_row = 0;
        left_cell = '0;
      end else begin
        grid_row++;
      end
    end else begin
      grid_col++;
    end
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic int unsigned pick_stall();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [gpc_pkg::TYPE_W-1:0] pick_kind(input int unsigned profile);
    int unsigned r;
    r = $urandom_range(0, 99);
    case (profile)
      0: return (r < 93) ? gpc_pkg::TYPE_FREE : gpc_pkg::TYPE_NOTURN;
      1: begin
        if (r < 65) return gpc_pkg::TYPE_FREE;
        if (r < 85) return gpc_pkg::TYPE_NOTURN;
        if (r < 97) return gpc_pkg::TYPE_BLOCKED;
        return TYPE_SPARE;
      end
      default: return gpc_pkg::TYPE_W'($urandom_range(0, 3));
    endcase
  endfunction

  // Offer one cell, wait for the handshake, then predict its result
  task automatic push_cell(input logic [gpc_pkg::TYPE_W-1:0] kind, input bit pinned,
                           input logic [gpc_pkg::CNT_W-1:0] want);
    int unsigned               gap;
    bit                        done;
    logic [gpc_pkg::CNT_W-1:0] total;
    gap = pick_gap();
    if (gap != 0) begin
      cell_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cell_ch.valid     <= 1'b1;
    cell_ch.cell_type <= kind;
    do @(posedge clk); while (!cell_ch.ready);
    cells_sent++;
    take_cell(kind, done, total);
    if (done) path_counts_due.push_back(pinned ? want : total);
  endtask

  // Hold the input until every pending count has arrived
  task automatic drain_counts();
    cell_ch.valid <= 1'b0;
    do @(posedge clk); while (path_counts_due.size() != 0);
  endtask

  // Write one dimension register once the block has gone quiet
  task automatic set_dim(input logic [gpc_pkg::CFG_IDX_W-1:0] which,
                         input logic [gpc_pkg::DIM_W-1:0] value);
    drain_counts();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= which;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (which == gpc_pkg::REG_NUM_ROWS) rows_reg = value;
    else cols_reg = value;
  endtask

  // Send cells until the grid wraps back to its start; optionally resize midway
  task automatic send_grid(input int unsigned profile, input bit broken);
    int unsigned total;
    int unsigned k;
    total = dim_eff(rows_reg) * dim_eff(cols_reg);
    if (broken && total >= 2) begin
      k = $urandom_range(1, total - 1);
      repeat (k) push_cell(pick_kind(profile), 1'b0, '0);
      // only shrink columns so every line-store read hits a written entry
      if ($urandom_range(0, 1) != 0)
        set_dim(gpc_pkg::REG_NUM_COLS,
                gpc_pkg::DIM_W'($urandom_range(0, dim_eff(cols_reg))));
      else
        set_dim(gpc_pkg::REG_NUM_ROWS,
                gpc_pkg::DIM_W'($urandom_range(0, dim_eff(rows_reg) + 3)));
    end
    do push_cell(pick_kind(profile), 1'b0, '0);
    while (grid_row != 0 || grid_col != 0);
  endtask

  // Result side: check each count and stall at random
  initial begin
    logic [gpc_pkg::CNT_W-1:0] want;
    int unsigned               hold_left;
    hold_left = 0;
    count_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (count_ch.valid && count_ch.ready) begin
        if (path_counts_due.size() == 0) begin
          faults++;
          if (faults <= SHOW_LIMIT)
            $display("%0t: path_count expected none got %0d", $time, count_ch.path_count);
        end else begin
          want = path_counts_due.pop_front();
          if (want !== count_ch.path_count) begin
            faults++;
            if (faults <= SHOW_LIMIT)
              $display("%0t: path_count expected %0d got %0d", $time, want,
                       count_ch.path_count);
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        count_ch.ready <= 1'b0;
      end else begin
        hold_left = pick_stall();
        count_ch.ready <= (hold_left == 0);
      end
    end
  end

  // Abort when no request moves on either side for too long
  initial begin
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((cell_ch.valid && cell_ch.ready) || (count_ch.valid && count_ch.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  // Stimulus
  initial begin
    int unsigned               grids;
    int unsigned               sel;
    int unsigned               random_start;
    logic [gpc_pkg::DIM_W-1:0] r_raw;
    logic [gpc_pkg::DIM_W-1:0] c_raw;
    bit                        paused_once;
    paused_once = 1'b0;
    rst_n             <= 1'b0;
    cfg_we            <= 1'b0;
    cfg_idx           <= gpc_pkg::REG_NUM_ROWS;
    cfg_data          <= '0;
    cell_ch.valid     <= 1'b0;
    cell_ch.cell_type <= gpc_pkg::TYPE_FREE;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Walk the directed table
    foreach (PLAN[i]) begin
      case (PLAN[i].op)
        STEP_ROWS: set_dim(gpc_pkg::REG_NUM_ROWS, PLAN[i].val);
        STEP_COLS: set_dim(gpc_pkg::REG_NUM_COLS, PLAN[i].val);
        default:   push_cell(PLAN[i].val[gpc_pkg::TYPE_W-1:0], PLAN[i].pinned,
                             PLAN[i].want);
      endcase
    end

    // Widest grid: columns clamp to a full-width line store, two rows
    set_dim(gpc_pkg::REG_NUM_ROWS, 10'd2);
    set_dim(gpc_pkg::REG_NUM_COLS, 10'd1023);
    send_grid(0, 1'b0);

    // Random phases of whole grids, mostly small
    random_start = cells_sent;
    while (cells_sent - random_start < RANDOM_CELLS) begin
      calm = ($urandom_range(0, 5) == 0);
      sel = $urandom_range(0, 99);
      if (sel < 60) begin
        r_raw = gpc_pkg::DIM_W'($urandom_range(1, 5));
        c_raw = gpc_pkg::DIM_W'($urandom_range(1, 5));
      end else if (sel < 80) begin
        r_raw = gpc_pkg::DIM_W'($urandom_range(1, 20));
        c_raw = gpc_pkg::DIM_W'($urandom_range(1, 20));
      end else if (sel < 90) begin
        r_raw = gpc_pkg::DIM_W'($urandom_range(0, 1));
        c_raw = gpc_pkg::DIM_W'($urandom_range(0, 8));
      end else if (sel < 95) begin
        r_raw = gpc_pkg::DIM_W'($urandom_range(1, 3));
        c_raw = gpc_pkg::DIM_W'($urandom_range(9, 40));
      end else begin
        r_raw = gpc_pkg::DIM_W'($urandom_range(9, 40));
        c_raw = gpc_pkg::DIM_W'($urandom_range(1, 3));
      end
      set_dim(gpc_pkg::REG_NUM_ROWS, r_raw);
      set_dim(gpc_pkg::REG_NUM_COLS, c_raw);
      grids = (dim_eff(r_raw) * dim_eff(c_raw) > 100) ? 1 : $urandom_range(1, 6);
      for (int g = 0; g < grids; g++) begin
        if (g > 0 && (!paused_once || $urandom_range(0, 9) == 0)) begin
          drain_counts();
          paused_once = 1'b1;
        end
        send_grid($urandom_range(0, 2), $urandom_range(0, 7) == 0);
      end
    end

    // Drain and report
    cell_ch.valid <= 1'b0;
    while (path_counts_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (faults == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

[grid_path_count_no_turn_cells_unit.f]
hdl/gpc_pkg.sv
hdl/gpc_cell_if.sv
hdl/gpc_ctrl.sv
hdl/gpc_line_mem.sv
hdl/grid_path_count_no_turn_cells_unit.sv
dv/tb.sv
